FILE: hdl/alr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg - shared types and codes for the aging page replacer
// Item kinds, attempt classes, sequencer states and the result beat layout.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int ELEM_W = 21;

  localparam logic [1:0] KIND_ACCESS  = 2'd0;
  localparam logic [1:0] KIND_AGE     = 2'd1;
  localparam logic [1:0] KIND_ADMIT   = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [2:0] CLS_OWN_PAGE  = 3'd1;
  localparam logic [2:0] CLS_UNOWNED   = 3'd2;
  localparam logic [2:0] CLS_OWN_STALE = 3'd3;
  localparam logic [2:0] CLS_RANDOM    = 3'd4;

  localparam logic [11:0] MIN_FREE_RESET = 12'd1000;
  localparam logic [15:0] AGE_FULL       = 16'hFFFF;

  // register index as seen in paddr[2]
  localparam logic REG_MIN_FREE = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ACC_CHK,
    S_TAKE_MAP,
    S_SCAN_MIN,
    S_VIC_CHK,
    S_PSCAN,
    S_SLOT_WR,
    S_SCAN_AGE,
    S_ADM_RD,
    S_ADM_CHK,
    S_ADM_MAP,
    S_REL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        hit;
    logic        fault;
    logic        replaced;
    logic [10:0] victim_page;
    logic [15:0] victim_history;
    logic [11:0] new_frame;
    logic [2:0]  attempt_class;
    logic [11:0] frames_freed;
  } res_t;

endpackage

FILE: hdl/alr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alr_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/alr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_div - reciprocal divider by a fixed divisor
// Multiply by a rounded-up reciprocal and shift, quotient registered; done
// pulses the cycle after start.
// ----------------------------------------------------------------------------
module alr_div #(
  parameter int DIVISOR = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [alr_pkg::ELEM_W-1:0] dividend,
  output logic                      done,
  output logic [alr_pkg::ELEM_W-1:0] quotient
);
  import alr_pkg::*;

  // exact for every dividend below 2**ELEM_W with shift ELEM_W + log2(divisor)
  localparam int              L      = $clog2(DIVISOR);
  localparam int              SH     = ELEM_W + L;
  localparam int              MW     = ELEM_W + 2;
  localparam int              PW     = ELEM_W + MW;
  localparam longint unsigned MULT   = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
                                       longint'(DIVISOR);
  localparam logic [MW-1:0]   MULT_C = MW'(MULT);

  logic              done_r, done_nxt;
  logic [ELEM_W-1:0] quo_r, quo_nxt;
  logic [PW-1:0]     prod;

  assign prod = PW'(dividend) * PW'(MULT_C);

  always_comb begin
    done_nxt = start;
    quo_nxt  = start ? ELEM_W'(prod >> SH) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/alr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ctrl - sequencer and shared scan datapath
// Walks page table and pool one entry per cycle through one compare/update
// path: minimum search, pool search, ageing, release; admit steps page by page.
// ----------------------------------------------------------------------------
module alr_ctrl #(
  parameter int POOL_FRAMES       = 4096,
  parameter int PAGES_PER_PROCESS = 2048,
  parameter int PROCESSES         = 16,
  parameter int RESERVED_PAGES    = 10,
  parameter int ELEMENTS_PER_PAGE = 1024,
  localparam int FW       = $clog2(POOL_FRAMES),
  localparam int PGW      = $clog2(PAGES_PER_PROCESS),
  localparam int PRW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1,
  localparam int PG_DEPTH = PROCESSES * PAGES_PER_PROCESS,
  localparam int AW       = $clog2(PG_DEPTH),
  localparam int PG_DW    = 18 + FW,
  localparam int PL_DW    = 1 + PRW + PGW + FW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [3:0]                   in_process,
  input  logic [alr_pkg::ELEM_W-1:0]   in_element_index,
  input  logic [11:0]                  in_random_slot,
  input  logic [11:0]                  min_free,
  output logic                         res_valid,
  output alr_pkg::res_t                res,
  input  logic                         res_take,
  output logic                         pg_rd_en,
  output logic [AW-1:0]                pg_rd_addr,
  input  logic [PG_DW-1:0]             pg_rd_data,
  output logic                         pg_wr_en,
  output logic [AW-1:0]                pg_wr_addr,
  output logic [PG_DW-1:0]             pg_wr_data,
  output logic                         pl_rd_en,
  output logic [FW-1:0]                pl_rd_addr,
  input  logic [PL_DW-1:0]             pl_rd_data,
  output logic                         pl_wr_en,
  output logic [FW-1:0]                pl_wr_addr,
  output logic [PL_DW-1:0]             pl_wr_data
);
  import alr_pkg::*;

  localparam int CW    = $clog2(POOL_FRAMES + 1);
  localparam int SW    = (PGW + 1 > CW) ? PGW + 1 : CW;
  localparam int CLR_N = (PG_DEPTH > POOL_FRAMES) ? PG_DEPTH : POOL_FRAMES;
  localparam int CLW   = $clog2(CLR_N);
  localparam int FRW   = $clog2(PAGES_PER_PROCESS + 1);

  state_t          state_r, state_nxt;
  logic [PRW-1:0]  proc_r, proc_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [PGW-1:0]  page_r, page_nxt;
  logic [11:0]     rnd_r, rnd_nxt;
  logic [SW-1:0]   scan_r, scan_nxt;
  logic            pv_r, pv_nxt;
  logic [SW-1:0]   pidx_r, pidx_nxt;
  logic [15:0]     min_r, min_nxt;
  logic [PGW-1:0]  victim_r, victim_nxt;
  logic [FW-1:0]   g_r, g_nxt;
  logic            c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic [FW-1:0]   i1_r, i1_nxt, i2_r, i2_nxt, i3_r, i3_nxt;
  logic [FW-1:0]   idx_r, idx_nxt;
  logic [2:0]      cls_r, cls_nxt;
  logic [CW-1:0]   count_r, count_nxt, head_r, head_nxt;
  logic [FRW-1:0]  freed_r, freed_nxt;
  logic            first_r, first_nxt;
  res_t            res_r, res_nxt;
  logic [CLW-1:0]  clr_r, clr_nxt;

  logic              div_start, div_done;
  logic [ELEM_W-1:0] quot;

  logic              acc, proc_ok;
  logic [PRW-1:0]    in_proc_w;
  logic [21:0]       page22;
  logic              page_ok;
  logic              pg_valid, pg_ref;
  logic [15:0]       pg_age;
  logic [FW-1:0]     pg_frame;
  logic              pl_none, pl_own;
  logic [PRW-1:0]    pl_owner;
  logic [PGW-1:0]    pl_page;
  logic [FW-1:0]     pl_frame;
  logic              take_ok;
  logic [15:0]       cnt16, mf16, r16, lo16, sum16;
  logic [SW-1:0]     scan_end;
  logic              scan_more, scan_fin;
  logic [FW-1:0]     rnd_idx, pick_idx;
  logic [2:0]        pick_cls;
  logic [PG_DW-1:0]  map_word;

  function automatic logic [11:0] nf12(input logic [FW-1:0] f);
    logic [13:0] w;
    w = 14'(f);
    return w[11:0];
  endfunction

  alr_div #(.DIVISOR(ELEMENTS_PER_PAGE)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_element_index),
    .done     (div_done),
    .quotient (quot)
  );

  assign acc       = in_valid && in_ready;
  assign proc_ok   = 7'(in_process) < 7'(PROCESSES);
  assign in_proc_w = PRW'(in_process);
  assign page22    = 22'(RESERVED_PAGES) + {1'b0, quot};
  assign page_ok   = page22 < 22'(PAGES_PER_PROCESS);

  assign pg_valid = pg_rd_data[FW+1];
  assign pg_ref   = pg_rd_data[FW];
  assign pg_age   = pg_rd_data[PG_DW-1 -: 16];
  assign pg_frame = pg_rd_data[FW-1:0];

  assign pl_none  = pl_rd_data[PL_DW-1];
  assign pl_owner = pl_rd_data[PL_DW-2 -: PRW];
  assign pl_page  = pl_rd_data[PGW+FW-1 -: PGW];
  assign pl_frame = pl_rd_data[FW-1:0];
  assign pl_own   = !pl_none && (pl_owner == proc_r);

  assign take_ok = (count_r != '0) && (head_r < CW'(POOL_FRAMES));
  assign cnt16   = 16'(count_r);
  assign mf16    = 16'(min_free);

  assign scan_end  = (state_r == S_PSCAN) ? SW'(POOL_FRAMES) : SW'(PAGES_PER_PROCESS);
  assign scan_more = scan_r < scan_end;
  assign scan_fin  = !scan_more && !pv_r;

  // fallback slot: saturate the offset, then clamp into the pool
  assign r16   = (min_free == '0) ? 16'd0 :
                 ((16'(rnd_r) > mf16 - 16'd1) ? mf16 - 16'd1 : 16'(rnd_r));
  assign lo16  = (16'(POOL_FRAMES) > mf16) ? 16'(POOL_FRAMES) - mf16 : 16'd0;
  assign sum16 = lo16 + r16;
  assign rnd_idx = (sum16 >= 16'(POOL_FRAMES)) ? FW'(POOL_FRAMES - 1) : FW'(sum16);

  assign pick_idx = c1_r ? i1_r : (c2_r ? i2_r : (c3_r ? i3_r : rnd_idx));
  assign pick_cls = c1_r ? CLS_OWN_PAGE : (c2_r ? CLS_UNOWNED :
                    (c3_r ? CLS_OWN_STALE : CLS_RANDOM));

  assign map_word = {AGE_FULL, 1'b1, 1'b1, pl_frame};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == CLW'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (!proc_ok) begin
            state_nxt = S_DONE;
          end else begin
            case (in_kind)
              KIND_ACCESS:  state_nxt = S_DIV;
              KIND_AGE:     state_nxt = S_SCAN_AGE;
              KIND_ADMIT:   state_nxt = S_ADM_RD;
              KIND_RELEASE: state_nxt = S_REL;
              default:      state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = page_ok ? S_ACC_CHK : S_DONE;
      end
      S_ACC_CHK: begin
        if (pg_valid) begin
          state_nxt = S_DONE;
        end else if (cnt16 > mf16) begin
          state_nxt = take_ok ? S_TAKE_MAP : S_DONE;
        end else if (cnt16 == mf16) begin
          state_nxt = S_SCAN_MIN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TAKE_MAP: state_nxt = S_DONE;
      S_SCAN_MIN: begin
        if (scan_fin) state_nxt = S_VIC_CHK;
      end
      S_VIC_CHK: state_nxt = S_PSCAN;
      S_PSCAN: begin
        if (scan_fin) state_nxt = S_SLOT_WR;
      end
      S_SLOT_WR: state_nxt = S_DONE;
      S_SCAN_AGE: begin
        if (scan_fin) state_nxt = S_DONE;
      end
      S_ADM_RD: begin
        state_nxt = (scan_r < SW'(RESERVED_PAGES)) ? S_ADM_CHK : S_DONE;
      end
      S_ADM_CHK: begin
        if (pg_valid) begin
          state_nxt = S_ADM_RD;
        end else begin
          state_nxt = take_ok ? S_ADM_MAP : S_DONE;
        end
      end
      S_ADM_MAP: state_nxt = S_ADM_RD;
      S_REL: begin
        if (scan_fin) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    proc_nxt   = proc_r;
    base_nxt   = base_r;
    page_nxt   = page_r;
    rnd_nxt    = rnd_r;
    scan_nxt   = scan_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    min_nxt    = min_r;
    victim_nxt = victim_r;
    g_nxt      = g_r;
    c1_nxt     = c1_r;
    c2_nxt     = c2_r;
    c3_nxt     = c3_r;
    i1_nxt     = i1_r;
    i2_nxt     = i2_r;
    i3_nxt     = i3_r;
    idx_nxt    = idx_r;
    cls_nxt    = cls_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    freed_nxt  = freed_r;
    first_nxt  = first_r;
    res_nxt    = res_r;
    clr_nxt    = clr_r;
    div_start  = 1'b0;
    pg_rd_en   = 1'b0;
    pg_rd_addr = '0;
    pg_wr_en   = 1'b0;
    pg_wr_addr = '0;
    pg_wr_data = '0;
    pl_rd_en   = 1'b0;
    pl_rd_addr = '0;
    pl_wr_en   = 1'b0;
    pl_wr_addr = '0;
    pl_wr_data = '0;

    case (state_r)
      S_CLEAR: begin
        // sweep both stores to their reset contents
        clr_nxt    = clr_r + CLW'(1);
        pg_wr_en   = int'(clr_r) < PG_DEPTH;
        pg_wr_addr = AW'(clr_r);
        pl_wr_en   = int'(clr_r) < POOL_FRAMES;
        pl_wr_addr = FW'(clr_r);
        pl_wr_data = {1'b1, PRW'(0), PGW'(0), FW'(clr_r)};
      end
      S_IDLE: begin
        if (acc) begin
          res_nxt   = '0;
          proc_nxt  = in_proc_w;
          base_nxt  = AW'(in_proc_w * PAGES_PER_PROCESS);
          rnd_nxt   = in_random_slot;
          first_nxt = 1'b1;
          freed_nxt = '0;
          div_start = (in_kind == KIND_ACCESS);
          scan_nxt  = (in_kind == KIND_AGE) ? SW'(RESERVED_PAGES) : SW'(0);
        end
      end
      S_DIV: begin
        if (div_done && page_ok) begin
          page_nxt   = PGW'(page22);
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(PGW'(page22));
        end
      end
      S_ACC_CHK: begin
        if (pg_valid) begin
          pg_wr_en       = 1'b1;
          pg_wr_addr     = base_r + AW'(page_r);
          pg_wr_data     = pg_rd_data;
          pg_wr_data[FW] = 1'b1;
          res_nxt.hit    = 1'b1;
        end else begin
          res_nxt.fault = 1'b1;
          if (cnt16 > mf16) begin
            pl_rd_en   = take_ok;
            pl_rd_addr = head_r[FW-1:0];
          end else if (cnt16 == mf16) begin
            scan_nxt   = SW'(RESERVED_PAGES);
            min_nxt    = AGE_FULL;
            victim_nxt = '0;
          end
        end
      end
      S_TAKE_MAP: begin
        head_nxt          = head_r + CW'(1);
        count_nxt         = count_r - CW'(1);
        pg_wr_en          = 1'b1;
        pg_wr_addr        = base_r + AW'(page_r);
        pg_wr_data        = map_word;
        res_nxt.new_frame = nf12(pl_frame);
      end
      S_SCAN_MIN: begin
        if (scan_more) begin
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(scan_r[PGW-1:0]);
          scan_nxt   = scan_r + SW'(1);
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_r;
        end
        if (pv_r && pg_valid && (pg_age < min_r)) begin
          min_nxt    = pg_age;
          victim_nxt = pidx_r[PGW-1:0];
        end
        if (scan_fin) begin
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(victim_r);
        end
      end
      S_VIC_CHK: begin
        g_nxt                  = pg_valid ? pg_frame : '0;
        res_nxt.replaced       = pg_valid;
        res_nxt.victim_page    = 11'(victim_r);
        res_nxt.victim_history = min_r;
        pg_wr_en               = 1'b1;
        pg_wr_addr             = base_r + AW'(victim_r);
        pg_wr_data             = {pg_age, 2'b00, FW'(0)};
        scan_nxt               = SW'(head_r);
        c1_nxt                 = 1'b0;
        c2_nxt                 = 1'b0;
        c3_nxt                 = 1'b0;
      end
      S_PSCAN: begin
        if (scan_more) begin
          pl_rd_en   = 1'b1;
          pl_rd_addr = scan_r[FW-1:0];
          scan_nxt   = scan_r + SW'(1);
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_r;
        end
        if (pv_r) begin
          // keep the first slot of each class
          if (pl_own && (pl_page == page_r) && !c1_r) begin
            c1_nxt = 1'b1;
            i1_nxt = pidx_r[FW-1:0];
          end
          if (pl_none && !c2_r) begin
            c2_nxt = 1'b1;
            i2_nxt = pidx_r[FW-1:0];
          end
          if (pl_own && !c3_r) begin
            c3_nxt = 1'b1;
            i3_nxt = pidx_r[FW-1:0];
          end
        end
        if (scan_fin) begin
          pl_rd_en   = 1'b1;
          pl_rd_addr = pick_idx;
          idx_nxt    = pick_idx;
          cls_nxt    = pick_cls;
        end
      end
      S_SLOT_WR: begin
        pg_wr_en              = 1'b1;
        pg_wr_addr            = base_r + AW'(page_r);
        pg_wr_data            = map_word;
        pl_wr_en              = 1'b1;
        pl_wr_addr            = idx_r;
        pl_wr_data            = {1'b0, proc_r, victim_r, g_r};
        res_nxt.new_frame     = nf12(pl_frame);
        res_nxt.attempt_class = cls_r;
      end
      S_SCAN_AGE: begin
        if (scan_more) begin
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(scan_r[PGW-1:0]);
          scan_nxt   = scan_r + SW'(1);
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_r;
        end
        if (pv_r && pg_valid) begin
          // shift the counter, move the reference bit into its top
          pg_wr_en   = 1'b1;
          pg_wr_addr = base_r + AW'(pidx_r[PGW-1:0]);
          pg_wr_data = {pg_ref, pg_age[15:1], 1'b1, 1'b0, pg_frame};
        end
      end
      S_ADM_RD: begin
        if (scan_r < SW'(RESERVED_PAGES)) begin
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(scan_r[PGW-1:0]);
        end
      end
      S_ADM_CHK: begin
        if (pg_valid) begin
          scan_nxt = scan_r + SW'(1);
        end else begin
          pl_rd_en   = take_ok;
          pl_rd_addr = head_r[FW-1:0];
        end
      end
      S_ADM_MAP: begin
        head_nxt   = head_r + CW'(1);
        count_nxt  = count_r - CW'(1);
        pg_wr_en   = 1'b1;
        pg_wr_addr = base_r + AW'(scan_r[PGW-1:0]);
        pg_wr_data = map_word;
        scan_nxt   = scan_r + SW'(1);
        first_nxt  = 1'b0;
        if (first_r) res_nxt.new_frame = nf12(pl_frame);
      end
      S_REL: begin
        if (scan_more) begin
          pg_rd_en   = 1'b1;
          pg_rd_addr = base_r + AW'(scan_r[PGW-1:0]);
          scan_nxt   = scan_r + SW'(1);
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_r;
        end
        if (pv_r && pg_valid) begin
          pg_wr_en   = 1'b1;
          pg_wr_addr = base_r + AW'(pidx_r[PGW-1:0]);
          pg_wr_data = {pg_age, 2'b00, FW'(0)};
          // drop the frame when the pool has no room below the head
          if (head_r != '0) begin
            head_nxt   = head_r - CW'(1);
            count_nxt  = count_r + CW'(1);
            freed_nxt  = freed_r + FRW'(1);
            pl_wr_en   = 1'b1;
            pl_wr_addr = FW'(head_r - CW'(1));
            pl_wr_data = {1'b1, PRW'(0), PGW'(0), pg_frame};
          end
        end
        if (scan_fin) res_nxt.frames_freed = 12'(freed_r);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= CW'(POOL_FRAMES);
      head_r  <= '0;
      clr_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      clr_r   <= clr_nxt;
      pv_r    <= pv_nxt;
    end
    proc_r   <= proc_nxt;
    base_r   <= base_nxt;
    page_r   <= page_nxt;
    rnd_r    <= rnd_nxt;
    scan_r   <= scan_nxt;
    pidx_r   <= pidx_nxt;
    min_r    <= min_nxt;
    victim_r <= victim_nxt;
    g_r      <= g_nxt;
    c1_r     <= c1_nxt;
    c2_r     <= c2_nxt;
    c3_r     <= c3_nxt;
    i1_r     <= i1_nxt;
    i2_r     <= i2_nxt;
    i3_r     <= i3_nxt;
    idx_r    <= idx_nxt;
    cls_r    <= cls_nxt;
    freed_r  <= freed_nxt;
    first_r  <= first_nxt;
    res_r    <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // frames move between pool head and free count one for one
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) + int'(head_r) == POOL_FRAMES)
    else $error("free count and pool head out of balance");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= CW'(POOL_FRAMES))
    else $error("pool head beyond pool");

  a_scan_data: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(pg_rd_en || pl_rd_en))
    else $error("scan data flagged without a read");

  a_hit_fault: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res_r.hit && res_r.fault))
    else $error("hit and fault both set");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> in_ready)
    else $error("sequencer not idle after result handoff");

endmodule

FILE: hdl/aging_lru_page_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_lru_page_replacer - aging page replacement with a shared frame pool
// Per-process page tables, aging counters and a free-frame pool in RAM,
// worked by one sequencer that scans them an entry per cycle.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in_      | sink      | in_valid / in_ready  | kind, process, element_index,
//           |           |                      | random_slot
//  out_     | source    | out_valid / out_ready| hit, fault, replaced, victim_*,
//           |           |                      | new_frame, attempt_class, freed
//  cfg      | slave     | psel/penable, pready | min_free_frames at offset 0
//
//  Sequencer steps per beat: hit (registered reciprocal page divide, entry
//  check, result), fault with a free frame (divide, check, take and map),
//  fault at the reserve (min-counter scan then pool scan), age tick (scan
//  of the unreserved pages), release (scan of all pages) and admit (read,
//  check and map per reserved page). One item at a time; in_ready is low
//  while the sequencer works.
//  After reset a clearing pass loads both RAMs; no item is taken meanwhile.
//  A result parks in the output register, so the next item may start while
//  out_ready is low; the sequencer holds at its final step only if a second
//  result is ready before the first is taken.
// ----------------------------------------------------------------------------
module aging_lru_page_replacer #(
  parameter int POOL_FRAMES       = 4096,
  parameter int PAGES_PER_PROCESS = 2048,
  parameter int PROCESSES         = 16,
  parameter int RESERVED_PAGES    = 10,
  parameter int ELEMENTS_PER_PAGE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_process,
  input  logic [20:0] in_element_index,
  input  logic [11:0] in_random_slot,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_fault,
  output logic        out_replaced,
  output logic [10:0] out_victim_page,
  output logic [15:0] out_victim_history,
  output logic [11:0] out_new_frame,
  output logic [2:0]  out_attempt_class,
  output logic [11:0] out_frames_freed,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import alr_pkg::*;

  localparam int FW       = $clog2(POOL_FRAMES);
  localparam int PGW      = $clog2(PAGES_PER_PROCESS);
  localparam int PRW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PG_DEPTH = PROCESSES * PAGES_PER_PROCESS;
  localparam int AW       = $clog2(PG_DEPTH);
  localparam int PG_DW    = 18 + FW;
  localparam int PL_DW    = 1 + PRW + PGW + FW;

  logic [11:0] min_free_r, min_free_nxt;
  logic        cfg_wr;

  logic        res_valid, res_take;
  res_t        res;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r, out_nxt;

  logic             pg_rd_en, pg_wr_en;
  logic [AW-1:0]    pg_rd_addr, pg_wr_addr;
  logic [PG_DW-1:0] pg_rd_data, pg_wr_data;
  logic             pl_rd_en, pl_wr_en;
  logic [FW-1:0]    pl_rd_addr, pl_wr_addr;
  logic [PL_DW-1:0] pl_rd_data, pl_wr_data;

  // config register: write on the access phase, read back live
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MIN_FREE) ? {20'd0, min_free_r} : 32'd0;

  always_comb begin
    min_free_nxt = min_free_r;
    if (cfg_wr && (paddr[2] == REG_MIN_FREE)) min_free_nxt = pwdata[11:0];
  end

  // output register: take a new result when the slot is empty or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_free_r  <= MIN_FREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      min_free_r  <= min_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_r.hit;
  assign out_fault          = out_r.fault;
  assign out_replaced       = out_r.replaced;
  assign out_victim_page    = out_r.victim_page;
  assign out_victim_history = out_r.victim_history;
  assign out_new_frame      = out_r.new_frame;
  assign out_attempt_class  = out_r.attempt_class;
  assign out_frames_freed   = out_r.frames_freed;

  // page table: {age counter, valid, reference, frame} per page
  alr_ram #(.DW(PG_DW), .DEPTH(PG_DEPTH)) u_page_ram (
    .clk     (clk),
    .wr_en   (pg_wr_en),
    .wr_addr (pg_wr_addr),
    .wr_data (pg_wr_data),
    .rd_en   (pg_rd_en),
    .rd_addr (pg_rd_addr),
    .rd_data (pg_rd_data)
  );

  // frame pool: {unowned, owner, page, frame} per slot
  alr_ram #(.DW(PL_DW), .DEPTH(POOL_FRAMES)) u_pool_ram (
    .clk     (clk),
    .wr_en   (pl_wr_en),
    .wr_addr (pl_wr_addr),
    .wr_data (pl_wr_data),
    .rd_en   (pl_rd_en),
    .rd_addr (pl_rd_addr),
    .rd_data (pl_rd_data)
  );

  alr_ctrl #(
    .POOL_FRAMES       (POOL_FRAMES),
    .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
    .PROCESSES         (PROCESSES),
    .RESERVED_PAGES    (RESERVED_PAGES),
    .ELEMENTS_PER_PAGE (ELEMENTS_PER_PAGE)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_process       (in_process),
    .in_element_index (in_element_index),
    .in_random_slot   (in_random_slot),
    .min_free         (min_free_r),
    .res_valid        (res_valid),
    .res              (res),
    .res_take         (res_take),
    .pg_rd_en         (pg_rd_en),
    .pg_rd_addr       (pg_rd_addr),
    .pg_rd_data       (pg_rd_data),
    .pg_wr_en         (pg_wr_en),
    .pg_wr_addr       (pg_wr_addr),
    .pg_wr_data       (pg_wr_data),
    .pl_rd_en         (pl_rd_en),
    .pl_rd_addr       (pl_rd_addr),
    .pl_rd_data       (pl_rd_data),
    .pl_wr_en         (pl_wr_en),
    .pl_wr_addr       (pl_wr_addr),
    .pl_wr_data       (pl_wr_data)
  );

endmodule
